// File: src/abeacc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abeacc_pkg
// Shared types, constants and the arctangent table for the angle bend
// energy accumulator.
// ----------------------------------------------------------------------------
package abeacc_pkg;

    localparam int MUL_W     = 48;
    localparam int PROD_W    = 64;
    localparam int CORD_W    = 34;
    localparam int CORD_FRAC = 30;
    localparam int ANG_W     = 26;

    localparam logic [23:0] LIN_K   = 24'd9432760;
    localparam logic [23:0] BEND_K  = 24'd367790;
    localparam logic [23:0] CUBIC_K = 24'd117441;

    localparam logic signed [ANG_W-1:0]  DEG90  = 26'sd5898240;
    localparam logic signed [ANG_W-1:0]  DEG180 = 26'sd11796480;
    localparam logic signed [PROD_W-1:0] F_ONE  = 64'sd16777216;
    localparam logic signed [PROD_W-1:0] T_MAX  = 64'sd549755813887;
    localparam logic signed [PROD_W-1:0] T_MIN  = -64'sd549755813888;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_BOTH = 2'd1;
    localparam logic [1:0] STAT_ONE  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_MULW,
        ST_CHK,
        ST_SQRT,
        ST_DIV,
        ST_COS,
        ST_CORD,
        ST_ANG,
        ST_FIN
    } state_t;

    typedef enum logic [3:0] {
        MOP_SQ,
        MOP_THR,
        MOP_DEN,
        MOP_KC,
        MOP_LIN,
        MOP_CC,
        MOP_D2,
        MOP_P,
        MOP_Q,
        MOP_F,
        MOP_TERM
    } mop_t;

    typedef enum logic [1:0] {
        RT_LEN1,
        RT_LEN2,
        RT_SIN
    } root_t;

    typedef struct packed {
        logic                     start;
        logic signed [MUL_W-1:0]  a;
        logic signed [MUL_W-1:0]  b;
    } mul_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] p;
    } mul_rsp_t;

    // atan(2^-i) in degrees, 2^-16 units
    function automatic logic [21:0] atan_deg(input logic [4:0] i);
        logic [21:0] v;
        begin
            case (i)
                5'd0:    v = 22'd2949120;
                5'd1:    v = 22'd1740967;
                5'd2:    v = 22'd919879;
                5'd3:    v = 22'd466945;
                5'd4:    v = 22'd234379;
                5'd5:    v = 22'd117304;
                5'd6:    v = 22'd58666;
                5'd7:    v = 22'd29335;
                5'd8:    v = 22'd14668;
                5'd9:    v = 22'd7334;
                5'd10:   v = 22'd3667;
                5'd11:   v = 22'd1833;
                5'd12:   v = 22'd917;
                5'd13:   v = 22'd458;
                5'd14:   v = 22'd229;
                5'd15:   v = 22'd115;
                5'd16:   v = 22'd57;
                5'd17:   v = 22'd29;
                5'd18:   v = 22'd14;
                5'd19:   v = 22'd7;
                5'd20:   v = 22'd4;
                5'd21:   v = 22'd2;
                5'd22:   v = 22'd1;
                default: v = 22'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// File: src/angle_bend_energy_accumulator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_bend_energy_accumulator_unit
// Angle bend energy per bond angle with a saturating running sum.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall, one angle item per transfer. in_stall is
// high while an item is being worked on; the block takes one item at a time.
// Output channel: out_valid/out_stall, one result item per input item, held
// in an output register, so the next input is taken while a result waits.
// Configuration: cfg_valid/cfg_ready/cfg_data writes min_length; cfg_ready
// is always high. Write only while the block is idle.
// Timing: short vectors finish after the nine length and dot products and
// the threshold square. Nearly all the time is in the shared bit-serial
// multiplier (one bit per cycle, 10 to 17 products per item); the square
// roots (three for a bent angle, two for a linear one), the division and
// the CORDIC take the rest.
// Reset: clears the running sum, sets min_length to 66 and empties the
// output register. A stalled result holds its values; when it is still held
// as the next item completes, the block waits before writing it out.
// ----------------------------------------------------------------------------
module angle_bend_energy_accumulator_unit #(
    parameter int CORDIC_STEPS = 24,
    parameter int FRAC_BITS    = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [23:0] first_dx,
    input  logic signed [23:0] first_dy,
    input  logic signed [23:0] first_dz,
    input  logic signed [23:0] second_dx,
    input  logic signed [23:0] second_dy,
    input  logic signed [23:0] second_dz,
    input  logic [23:0]        force_const,
    input  logic [23:0]        ref_angle,
    input  logic               is_linear,
    input  logic               last_angle,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [39:0] energy_term,
    output logic signed [47:0] energy_total,
    output logic [1:0]         status,
    output logic               last_out
);
    import abeacc_pkg::*;

    localparam int CW_C = FRAC_BITS + 2;
    localparam logic [MUL_W-1:0]  ONE_M  = MUL_W'(1) << FRAC_BITS;
    localparam logic [PROD_W-1:0] SQ_TOP = PROD_W'(1) << 60;
    localparam logic [PROD_W-1:0] SIN_V  = PROD_W'(1) << (2 * FRAC_BITS);

    state_t state_reg, state_next;
    mop_t   mop_reg;
    root_t  rsel_reg;
    logic [3:0] idx_reg;
    logic [5:0] cnt_reg;

    logic signed [23:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic [23:0]        k_reg, ref_reg;
    logic               lin_reg, last_reg;
    logic [15:0]        ml_reg;

    logic [47:0]        l1_reg, l2_reg;
    logic signed [48:0] dot_reg;
    logic [31:0]        thr_reg;
    logic [PROD_W-1:0]  sq_v_reg, sq_r_reg, sq_b_reg;
    logic [29:0]        len1_reg, len2_reg;
    logic [PROD_W-1:0]  num_reg, den_reg, rem_reg;
    logic [FRAC_BITS-1:0] quo_reg;
    logic [FRAC_BITS:0]   mag_reg;
    logic signed [CW_C-1:0]   cos_reg;
    logic signed [CORD_W-1:0] x_reg, y_reg;
    logic signed [ANG_W-1:0]  z_reg, d_reg;
    logic signed [39:0] ta_reg, tb_reg, term_reg;
    logic [1:0]         stat_reg;
    logic signed [47:0] sum_reg;

    logic               out_valid_reg;
    logic signed [39:0] energy_term_reg;
    logic signed [47:0] energy_total_reg;
    logic [1:0]         status_reg;
    logic               last_out_reg;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    logic accept, out_free, short1, short2;
    logic [PROD_W-1:0] sq_t, sq_r_step, rem_sh;
    logic sq_ge, sq_last, div_ge, div_last, cord_last, y_pos;
    logic signed [CORD_W-1:0] xs, ys, cx, sy;
    logic signed [ANG_W-1:0]  atan_s, theta;
    logic signed [PROD_W-1:0] rnd16, rnd24, rndf;
    logic signed [48:0] sum_add;
    logic signed [47:0] sum_sat;
    logic [48:0]        dot_mag;
    logic signed [MUL_W-1:0] sx_c, sx_d;

    function automatic logic signed [PROD_W-1:0] rnd(
        input logic signed [PROD_W-1:0] v,
        input int s
    );
        logic signed [PROD_W-1:0] h;
        begin
            h = PROD_W'(1) << (s - 1);
            return (v + h) >>> s;
        end
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [PROD_W-1:0] v);
        logic signed [39:0] r;
        begin
            if (v > T_MAX)
                r = T_MAX[39:0];
            else if (v < T_MIN)
                r = T_MIN[39:0];
            else
                r = v[39:0];
            return r;
        end
    endfunction

    function automatic logic signed [MUL_W-1:0] sx24(input logic signed [23:0] v);
        begin
            return {{(MUL_W-24){v[23]}}, v};
        end
    endfunction

    function automatic logic signed [MUL_W-1:0] sx40(input logic signed [39:0] v);
        begin
            return {{(MUL_W-40){v[39]}}, v};
        end
    endfunction

    abeacc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign short1   = (l1_reg == '0) || (l1_reg < 48'(thr_reg));
    assign short2   = (l2_reg == '0) || (l2_reg < 48'(thr_reg));

    assign sq_t      = sq_r_reg + sq_b_reg;
    assign sq_ge     = sq_v_reg >= sq_t;
    assign sq_r_step = sq_ge ? ((sq_r_reg >> 1) + sq_b_reg) : (sq_r_reg >> 1);
    assign sq_last   = sq_b_reg == PROD_W'(1);

    assign rem_sh   = {rem_reg[PROD_W-2:0], 1'b0};
    assign div_ge   = rem_sh >= den_reg;
    assign div_last = cnt_reg == 6'(FRAC_BITS - 1);

    assign xs        = x_reg >>> cnt_reg[4:0];
    assign ys        = y_reg >>> cnt_reg[4:0];
    assign atan_s    = $signed(ANG_W'(atan_deg(cnt_reg[4:0])));
    assign y_pos     = y_reg > 0;
    assign cord_last = cnt_reg == 6'(CORDIC_STEPS - 1);
    assign cx = {{(CORD_W-CW_C){cos_reg[CW_C-1]}}, cos_reg} <<< (CORD_FRAC - FRAC_BITS);
    assign sy = $signed(CORD_W'(sq_r_step[FRAC_BITS:0])) <<< (CORD_FRAC - FRAC_BITS);

    assign theta = (z_reg < 0) ? '0 : ((z_reg > DEG180) ? DEG180 : z_reg);

    assign rnd16 = rnd(mul_rsp.p, 16);
    assign rnd24 = rnd(mul_rsp.p, 24);
    assign rndf  = rnd(mul_rsp.p, FRAC_BITS);

    assign dot_mag = dot_reg[48] ? 49'(-dot_reg) : 49'(dot_reg);
    assign sx_c    = {{(MUL_W-CW_C){cos_reg[CW_C-1]}}, cos_reg};
    assign sx_d    = {{(MUL_W-ANG_W){d_reg[ANG_W-1]}}, d_reg};

    assign sum_add = {sum_reg[47], sum_reg} + {{9{term_reg[39]}}, term_reg};
    assign sum_sat = (sum_add[48] != sum_add[47]) ?
                     (sum_add[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}}) : sum_add[47:0];

    // operand select for the shared multiplier
    always_comb
    begin
        mul_req.a = '0;
        mul_req.b = '0;
        case (mop_reg)
            MOP_SQ:
            begin
                case (idx_reg)
                    4'd0:    begin mul_req.a = sx24(ax_reg); mul_req.b = sx24(ax_reg); end
                    4'd1:    begin mul_req.a = sx24(ay_reg); mul_req.b = sx24(ay_reg); end
                    4'd2:    begin mul_req.a = sx24(az_reg); mul_req.b = sx24(az_reg); end
                    4'd3:    begin mul_req.a = sx24(bx_reg); mul_req.b = sx24(bx_reg); end
                    4'd4:    begin mul_req.a = sx24(by_reg); mul_req.b = sx24(by_reg); end
                    4'd5:    begin mul_req.a = sx24(bz_reg); mul_req.b = sx24(bz_reg); end
                    4'd6:    begin mul_req.a = sx24(ax_reg); mul_req.b = sx24(bx_reg); end
                    4'd7:    begin mul_req.a = sx24(ay_reg); mul_req.b = sx24(by_reg); end
                    default: begin mul_req.a = sx24(az_reg); mul_req.b = sx24(bz_reg); end
                endcase
            end
            MOP_THR:
            begin
                mul_req.a = MUL_W'(ml_reg);
                mul_req.b = MUL_W'(ml_reg);
            end
            MOP_DEN:
            begin
                mul_req.a = MUL_W'(len1_reg);
                mul_req.b = MUL_W'(len2_reg);
            end
            MOP_KC:
            begin
                mul_req.a = MUL_W'(k_reg);
                mul_req.b = MUL_W'(LIN_K);
            end
            MOP_LIN:
            begin
                mul_req.a = sx40(ta_reg);
                mul_req.b = sx_c + ONE_M;
            end
            MOP_CC:
            begin
                mul_req.a = sx_c;
                mul_req.b = sx_c;
            end
            MOP_D2:
            begin
                mul_req.a = sx_d;
                mul_req.b = sx_d;
            end
            MOP_P:
            begin
                mul_req.a = MUL_W'(k_reg);
                mul_req.b = MUL_W'(BEND_K);
            end
            MOP_Q:
            begin
                mul_req.a = sx40(ta_reg);
                mul_req.b = sx40(tb_reg);
            end
            MOP_F:
            begin
                mul_req.a = sx_d;
                mul_req.b = MUL_W'(CUBIC_K);
            end
            default:
            begin
                mul_req.a = sx40(ta_reg);
                mul_req.b = sx40(tb_reg);
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_MUL;
            ST_MUL:  state_next = ST_MULW;
            ST_MULW:
            begin
                if (mul_rsp.done)
                begin
                    case (mop_reg)
                        MOP_THR:  state_next = ST_CHK;
                        MOP_DEN:  state_next = (num_reg >= mul_rsp.p) ? ST_COS : ST_DIV;
                        MOP_LIN:  state_next = ST_FIN;
                        MOP_CC:   state_next = ST_SQRT;
                        MOP_TERM: state_next = ST_FIN;
                        default:  state_next = ST_MUL;
                    endcase
                end
            end
            ST_CHK:  state_next = (short1 || short2) ? ST_FIN : ST_SQRT;
            ST_SQRT:
            begin
                if (sq_last)
                begin
                    case (rsel_reg)
                        RT_LEN1: state_next = ST_SQRT;
                        RT_LEN2: state_next = ST_MUL;
                        default: state_next = ST_CORD;
                    endcase
                end
            end
            ST_DIV:  if (div_last) state_next = ST_COS;
            ST_COS:  state_next = ST_MUL;
            ST_CORD: if (cord_last) state_next = ST_ANG;
            ST_ANG:  state_next = ST_MUL;
            ST_FIN:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall      = state_reg != ST_IDLE;
        mul_req.start = state_reg == ST_MUL;
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ml_reg        <= 16'd66;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                ml_reg <= cfg_data;
            if (state_reg == ST_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
                sum_reg       <= last_reg ? '0 : sum_sat;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ax_reg   <= first_dx;
                    ay_reg   <= first_dy;
                    az_reg   <= first_dz;
                    bx_reg   <= second_dx;
                    by_reg   <= second_dy;
                    bz_reg   <= second_dz;
                    k_reg    <= force_const;
                    ref_reg  <= ref_angle;
                    lin_reg  <= is_linear;
                    last_reg <= last_angle;
                    l1_reg   <= '0;
                    l2_reg   <= '0;
                    dot_reg  <= '0;
                    idx_reg  <= '0;
                    mop_reg  <= MOP_SQ;
                end
            end
            ST_MULW:
            begin
                if (mul_rsp.done)
                begin
                    case (mop_reg)
                        MOP_SQ:
                        begin
                            if (idx_reg < 4'd3)
                                l1_reg <= l1_reg + mul_rsp.p[47:0];
                            else if (idx_reg < 4'd6)
                                l2_reg <= l2_reg + mul_rsp.p[47:0];
                            else
                                dot_reg <= dot_reg + $signed(mul_rsp.p[48:0]);
                            if (idx_reg == 4'd8)
                                mop_reg <= MOP_THR;
                            idx_reg <= idx_reg + 4'd1;
                        end
                        MOP_THR: thr_reg <= mul_rsp.p[31:0];
                        MOP_DEN:
                        begin
                            den_reg <= mul_rsp.p;
                            rem_reg <= num_reg;
                            quo_reg <= '0;
                            cnt_reg <= '0;
                            mag_reg <= (FRAC_BITS+1)'(1) << FRAC_BITS;
                        end
                        MOP_KC:
                        begin
                            ta_reg  <= rnd16[39:0];
                            mop_reg <= MOP_LIN;
                        end
                        MOP_LIN: term_reg <= sat40(rndf);
                        MOP_CC:
                        begin
                            sq_v_reg <= SIN_V - mul_rsp.p;
                            sq_r_reg <= '0;
                            sq_b_reg <= SQ_TOP;
                            rsel_reg <= RT_SIN;
                        end
                        MOP_D2:
                        begin
                            ta_reg  <= rnd16[39:0];
                            mop_reg <= MOP_P;
                        end
                        MOP_P:
                        begin
                            tb_reg  <= rnd16[39:0];
                            mop_reg <= MOP_Q;
                        end
                        MOP_Q:
                        begin
                            ta_reg  <= rnd24[39:0];
                            mop_reg <= MOP_F;
                        end
                        MOP_F:
                        begin
                            tb_reg  <= 40'(F_ONE - rnd16);
                            mop_reg <= MOP_TERM;
                        end
                        default: term_reg <= sat40(rnd24);
                    endcase
                end
            end
            ST_CHK:
            begin
                term_reg <= '0;
                stat_reg <= (short1 && short2) ? STAT_BOTH :
                            ((short1 || short2) ? STAT_ONE : STAT_OK);
                num_reg  <= PROD_W'(dot_mag) << 12;
                sq_v_reg <= {4'b0, l1_reg, 12'b0};
                sq_r_reg <= '0;
                sq_b_reg <= SQ_TOP;
                rsel_reg <= RT_LEN1;
            end
            ST_SQRT:
            begin
                sq_v_reg <= sq_ge ? (sq_v_reg - sq_t) : sq_v_reg;
                sq_r_reg <= sq_r_step;
                sq_b_reg <= sq_b_reg >> 2;
                if (sq_last)
                begin
                    case (rsel_reg)
                        RT_LEN1:
                        begin
                            len1_reg <= sq_r_step[29:0];
                            sq_v_reg <= {4'b0, l2_reg, 12'b0};
                            sq_r_reg <= '0;
                            sq_b_reg <= SQ_TOP;
                            rsel_reg <= RT_LEN2;
                        end
                        RT_LEN2:
                        begin
                            len2_reg <= sq_r_step[29:0];
                            mop_reg  <= MOP_DEN;
                        end
                        default:
                        begin
                            cnt_reg <= '0;
                            if (cos_reg < 0)
                            begin
                                x_reg <= sy;
                                y_reg <= -cx;
                                z_reg <= DEG90;
                            end
                            else
                            begin
                                x_reg <= cx;
                                y_reg <= sy;
                                z_reg <= '0;
                            end
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                rem_reg <= div_ge ? (rem_sh - den_reg) : rem_sh;
                quo_reg <= {quo_reg[FRAC_BITS-2:0], div_ge};
                cnt_reg <= cnt_reg + 6'd1;
                if (div_last)
                    mag_reg <= {1'b0, quo_reg[FRAC_BITS-2:0], div_ge};
            end
            ST_COS:
            begin
                cos_reg <= dot_reg[48] ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
                mop_reg <= lin_reg ? MOP_KC : MOP_CC;
            end
            ST_CORD:
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (y_pos)
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_s;
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_s;
                end
            end
            ST_ANG:
            begin
                d_reg   <= theta - $signed({2'b00, ref_reg});
                mop_reg <= MOP_D2;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    energy_term_reg  <= term_reg;
                    energy_total_reg <= sum_sat;
                    status_reg       <= stat_reg;
                    last_out_reg     <= last_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign energy_term  = energy_term_reg;
    assign energy_total = energy_total_reg;
    assign status       = status_reg;
    assign last_out     = last_out_reg;

endmodule

// File: src/abeacc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abeacc_mul
// Shared bit-serial signed multiplier: magnitudes by shift and add, one
// multiplier bit per cycle, sign applied at the end.
// ----------------------------------------------------------------------------
module abeacc_mul (
    input  logic                 clk,
    input  logic                 rst_n,
    input  abeacc_pkg::mul_req_t req,
    output abeacc_pkg::mul_rsp_t rsp
);
    import abeacc_pkg::*;

    logic                     busy_reg;
    logic                     done_reg;
    logic                     neg_reg;
    logic [PROD_W-1:0]        acc_reg;
    logic [PROD_W-1:0]        mcand_reg;
    logic [MUL_W-1:0]         mplier_reg;
    logic signed [PROD_W-1:0] p_reg;
    logic [MUL_W-1:0]         a_mag;
    logic [MUL_W-1:0]         b_mag;

    assign a_mag = req.a[MUL_W-1] ? (~req.a + 1'b1) : req.a;
    assign b_mag = req.b[MUL_W-1] ? (~req.b + 1'b1) : req.b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (mplier_reg == '0))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= PROD_W'(a_mag);
            mplier_reg <= b_mag;
            neg_reg    <= req.a[MUL_W-1] ^ req.b[MUL_W-1];
        end
        else if (busy_reg)
        begin
            if (mplier_reg == '0)
            begin
                p_reg <= neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
            end
            else
            begin
                if (mplier_reg[0])
                begin
                    acc_reg <= acc_reg + mcand_reg;
                end
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.p    = p_reg;

endmodule

// File: src/abeacc_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abeacc_chk
// Port-level checks for the angle bend energy accumulator, bound to the top.
// ----------------------------------------------------------------------------
module abeacc_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [39:0] energy_term,
    input logic signed [47:0] energy_total,
    input logic [1:0]         status,
    input logic               last_out
);
    import abeacc_pkg::*;

    // one item at a time: an accepted item blocks the input
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again straight after an item");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(energy_total)
            && $stable(energy_term) && $stable(last_out))
        else $error("stalled result changed");

    // short vectors give no energy
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STAT_OK) |-> energy_term == '0)
        else $error("short vector item with non-zero term");

    // a result taken while idle is not followed by a busy block still showing a result unless an item was offered
    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !in_stall |=> !out_valid || !in_stall
            || $past(in_valid))
        else $error("result appeared without an item");

endmodule

bind angle_bend_energy_accumulator_unit abeacc_chk u_abeacc_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .energy_term  (energy_term),
    .energy_total (energy_total),
    .status       (status),
    .last_out     (last_out)
);
